>>> src/cpe_pkg.sv
package cpe_pkg;

   localparam int MAX_CAND    = 16;
   localparam int MAX_ENTRIES = 64;
   localparam int CAND_W      = 4;
   localparam int IDX_W       = 6;
   localparam int TOTAL_W     = 7;
   localparam int POS_W       = 5;
   localparam int RANK_W      = 64;
   localparam int VCNT_W      = 16;
   localparam int TALLY_W     = 32;
   localparam int TADDR_W     = 8;
   localparam int TALLY_DEPTH = 256;

   localparam logic [TOTAL_W-1:0] ENTRIES_FULL = TOTAL_W'(MAX_ENTRIES);
   localparam logic [POS_W-1:0]   CAND_MIN     = POS_W'(2);
   localparam logic [POS_W-1:0]   CAND_MAX     = POS_W'(MAX_CAND);
   localparam logic [VCNT_W-1:0]  VCNT_SAT     = 16'hFFFF;

   // command codes
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_SWAP = 2'd1;
   localparam logic [1:0] CMD_EVAL = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;
   localparam logic [1:0] ST_ZERO = 2'd3;

   // register indexes
   localparam logic CSR_CAND_COUNT = 1'b0;
   localparam logic CSR_VOTER_TOTAL = 1'b1;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [CAND_W-1:0] candidate;
      logic [15:0]       weight;
      logic              last;
      logic [3:0]        position;
      logic [IDX_W-1:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               has_winner;
      logic [CAND_W-1:0]  winner;
      logic [TOTAL_W-1:0] entries_used;
   } rsp_type;

   typedef struct packed {
      logic              rank_en;
      logic              cnt_en;
      logic [IDX_W-1:0]  addr;
      logic [RANK_W-1:0] rank;
      logic [VCNT_W-1:0] cnt;
   } store_wr_type;

endpackage

>>> src/cpe_store.sv
module cpe_store
   import cpe_pkg::*;
(
   input  logic              clock,
   input  store_wr_type      wr,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [RANK_W-1:0] rd_rank,
   output logic [VCNT_W-1:0] rd_cnt
);

   logic [RANK_W-1:0] rank_mem [MAX_ENTRIES];
   logic [VCNT_W-1:0] cnt_mem  [MAX_ENTRIES];
   logic [RANK_W-1:0] rd_rank_ff;
   logic [VCNT_W-1:0] rd_cnt_ff;

   // write ranking and voter count independently
   always_ff @(posedge clock) begin
      if (wr.rank_en) begin
         rank_mem[wr.addr] <= wr.rank;
      end
      if (wr.cnt_en) begin
         cnt_mem[wr.addr] <= wr.cnt;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_rank_ff <= rank_mem[rd_addr];
         rd_cnt_ff  <= cnt_mem[rd_addr];
      end
   end

   assign rd_rank = rd_rank_ff;
   assign rd_cnt  = rd_cnt_ff;

endmodule

>>> src/condorcet_profile_engine.sv
// Weighted ranked-ballot table with a pairwise majority-winner check.
// Commands arrive one beat at a time on req_ (valid/ready); every command
// returns exactly one beat on rsp_ holding status, winner and table size.
// Registers are written through csr_ (candidate count, voter total); the
// user must write them only while the block is idle; the block does not enforce it.
// All commands are driven by one sequencer around a ballot store and a
// 256-entry pairwise tally memory, each with one write and one read port:
//   load   : takes one candidate position per beat, commits on the last beat
//   swap   : reads the entry, searches the table for the swapped ranking,
//            then adjusts counts, rewrites in place, appends or moves the last entry in
//   eval   : clears the tally memory, adds each entry's count per candidate
//            pair, then runs the pairwise compares of the winner scan
// req_ready is high only while the sequencer is idle.
// A finished result sits in the output register; when the receiver stalls
// the sequencer waits with the next result until that beat is taken.
// Reset (synchronous) empties the table, drops a partial ballot and sets
// candidate count 4, voter total 1; no clearing pass is needed.
module condorcet_profile_engine
   import cpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_SW_CHK, S_SR_ADDR, S_SR_CMP, S_SW_UPD, S_SW_DEC, S_SW_APPEND,
      S_SW_MOVE_RD, S_SW_MOVE_WR, S_EV_CLR, S_EV_ERD, S_EV_ELAT, S_EV_TRD,
      S_EV_TWR, S_EV_WRD, S_EV_WCMP, S_DONE
   } state_type;

   state_type          state_ff;
   logic [POS_W-1:0]   cand_count_ff;
   logic [15:0]        voter_total_ff;
   logic [TOTAL_W-1:0] entry_total_ff;
   logic [POS_W-1:0]   load_pos_ff;
   logic [RANK_W-1:0]  load_rank_ff;
   req_type            req_ff;
   logic [RANK_W-1:0]  cur_rank_ff;
   logic [VCNT_W-1:0]  cur_cnt_ff;
   logic [RANK_W-1:0]  new_rank_ff;
   logic [TOTAL_W-1:0] i_ff;
   logic [IDX_W-1:0]   found_ff;
   logic [VCNT_W-1:0]  found_cnt_ff;
   logic               hit_ff;
   logic [TADDR_W-1:0] t_ff;
   logic [TADDR_W-1:0] taddr_ff;
   logic [3:0]         j_ff;
   logic [3:0]         k_ff;
   logic [3:0]         x_ff;
   logic [1:0]         st_ff;
   logic               hw_ff;
   logic [CAND_W-1:0]  win_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic [TALLY_W-1:0] tally_mem [TALLY_DEPTH];
   logic [TALLY_W-1:0] tally_rd_ff;

   logic [POS_W-1:0]   cc;
   logic [RANK_W-1:0]  mask;
   store_wr_type       st_wr;
   logic               st_rd_en;
   logic [IDX_W-1:0]   st_rd_addr;
   logic [RANK_W-1:0]  rd_rank;
   logic [VCNT_W-1:0]  rd_cnt;
   logic               tally_we;
   logic [TADDR_W-1:0] tally_waddr;
   logic [TALLY_W-1:0] tally_wdata;
   logic [TADDR_W-1:0] tally_raddr;
   logic [TADDR_W-1:0] taddr;
   logic               ld_over;
   logic [RANK_W-1:0]  ld_rank;
   logic [POS_W-1:0]   ld_pos1;
   logic [1:0]         ld_status;
   logic               ld_commit;
   logic [RANK_W-1:0]  sw_rank;
   logic [3:0]         pos1;
   logic               sw_bad;
   logic               empties;
   logic [VCNT_W-1:0]  found_inc;
   logic               req_fire;

   cpe_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_rank (rd_rank),
      .rd_cnt  (rd_cnt)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // clamp candidate count and build compare mask
   always_comb begin
      if (cand_count_ff < CAND_MIN) begin
         cc = CAND_MIN;
      end else if (cand_count_ff > CAND_MAX) begin
         cc = CAND_MAX;
      end else begin
         cc = cand_count_ff;
      end
      for (int p = 0; p < MAX_CAND; p++) begin
         mask[4*p +: 4] = (POS_W'(p) < cc) ? 4'hF : 4'h0;
      end
   end

   // load step
   always_comb begin
      ld_over = (load_pos_ff >= cc);
      ld_rank = load_rank_ff;
      ld_rank[{load_pos_ff[3:0], 2'b00} +: 4] = req_data.candidate;
      ld_pos1 = load_pos_ff + POS_W'(1);
      ld_commit = 1'b0;
      if (ld_over) begin
         ld_status = ST_BAD;
      end else if (!req_data.last) begin
         ld_status = ST_OK;
      end else if (ld_pos1 != cc) begin
         ld_status = ST_BAD;
      end else if (req_data.weight == '0) begin
         ld_status = ST_ZERO;
      end else if (entry_total_ff >= ENTRIES_FULL) begin
         ld_status = ST_FULL;
      end else begin
         ld_status = ST_OK;
         ld_commit = 1'b1;
      end
   end

   // swap helpers
   always_comb begin
      pos1    = req_ff.position + 4'd1;
      sw_rank = rd_rank;
      sw_rank[{req_ff.position, 2'b00} +: 4] = rd_rank[{pos1, 2'b00} +: 4];
      sw_rank[{pos1, 2'b00} +: 4] = rd_rank[{req_ff.position, 2'b00} +: 4];
      sw_bad  = ({1'b0, req_data.entry_index} >= entry_total_ff) ||
                ({1'b0, req_data.position} + POS_W'(1) >= cc);
      empties = (cur_cnt_ff == VCNT_W'(1));
      found_inc = (found_cnt_ff == VCNT_SAT) ? VCNT_SAT : found_cnt_ff + VCNT_W'(1);
      taddr   = {cur_rank_ff[{j_ff, 2'b00} +: 4], cur_rank_ff[{k_ff, 2'b00} +: 4]};
   end

   // memory port control
   always_comb begin
      st_wr       = '0;
      st_rd_en    = 1'b0;
      st_rd_addr  = '0;
      tally_we    = 1'b0;
      tally_waddr = '0;
      tally_wdata = '0;
      tally_raddr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_data.cmd == CMD_SWAP) begin
               st_rd_en   = 1'b1;
               st_rd_addr = req_data.entry_index;
            end
            if (req_valid && req_data.cmd == CMD_LOAD && ld_commit) begin
               st_wr.rank_en = 1'b1;
               st_wr.cnt_en  = 1'b1;
               st_wr.addr    = entry_total_ff[IDX_W-1:0];
               st_wr.rank    = ld_rank;
               st_wr.cnt     = req_data.weight;
            end
         end
         S_SR_ADDR: begin
            st_rd_en   = 1'b1;
            st_rd_addr = i_ff[IDX_W-1:0];
         end
         S_SW_UPD: begin
            if (hit_ff) begin
               st_wr.cnt_en = 1'b1;
               st_wr.addr   = found_ff;
               st_wr.cnt    = found_inc;
            end else if (empties) begin
               st_wr.rank_en = 1'b1;
               st_wr.cnt_en  = 1'b1;
               st_wr.addr    = req_ff.entry_index;
               st_wr.rank    = new_rank_ff;
               st_wr.cnt     = VCNT_W'(1);
            end else if (entry_total_ff < ENTRIES_FULL) begin
               st_wr.cnt_en = 1'b1;
               st_wr.addr   = req_ff.entry_index;
               st_wr.cnt    = cur_cnt_ff - VCNT_W'(1);
            end
         end
         S_SW_DEC: begin
            st_wr.cnt_en = 1'b1;
            st_wr.addr   = req_ff.entry_index;
            st_wr.cnt    = cur_cnt_ff - VCNT_W'(1);
         end
         S_SW_APPEND: begin
            st_wr.rank_en = 1'b1;
            st_wr.cnt_en  = 1'b1;
            st_wr.addr    = entry_total_ff[IDX_W-1:0];
            st_wr.rank    = new_rank_ff;
            st_wr.cnt     = VCNT_W'(1);
         end
         S_SW_MOVE_RD: begin
            st_rd_en   = 1'b1;
            st_rd_addr = IDX_W'(entry_total_ff - TOTAL_W'(1));
         end
         S_SW_MOVE_WR: begin
            st_wr.rank_en = 1'b1;
            st_wr.cnt_en  = 1'b1;
            st_wr.addr    = req_ff.entry_index;
            st_wr.rank    = rd_rank;
            st_wr.cnt     = rd_cnt;
         end
         S_EV_CLR: begin
            tally_we    = 1'b1;
            tally_waddr = t_ff;
         end
         S_EV_ERD: begin
            st_rd_en   = 1'b1;
            st_rd_addr = i_ff[IDX_W-1:0];
         end
         S_EV_TRD: begin
            tally_raddr = taddr;
         end
         S_EV_TWR: begin
            tally_we    = 1'b1;
            tally_waddr = taddr_ff;
            tally_wdata = tally_rd_ff + TALLY_W'(cur_cnt_ff);
         end
         S_EV_WRD: begin
            tally_raddr = {x_ff, j_ff};
         end
         default: begin
         end
      endcase
   end

   // pairwise tally memory
   always_ff @(posedge clock) begin
      if (tally_we) begin
         tally_mem[tally_waddr] <= tally_wdata;
      end
      tally_rd_ff <= tally_mem[tally_raddr];
   end

   // sequencer, table bookkeeping and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cand_count_ff  <= POS_W'(4);
         voter_total_ff <= 16'd1;
         entry_total_ff <= '0;
         load_pos_ff    <= '0;
         load_rank_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CAND_COUNT) begin
               cand_count_ff <= csr_wdata[POS_W-1:0];
            end else begin
               voter_total_ff <= csr_wdata;
            end
         end
         // drop the result once taken, unless a new one replaces it now
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  req_ff <= req_data;
                  hw_ff  <= 1'b0;
                  win_ff <= '0;
                  case (req_data.cmd)
                     CMD_LOAD: begin
                        st_ff    <= ld_status;
                        state_ff <= S_DONE;
                        if (ld_over || req_data.last) begin
                           load_pos_ff  <= '0;
                           load_rank_ff <= '0;
                        end else begin
                           load_pos_ff  <= ld_pos1;
                           load_rank_ff <= ld_rank;
                        end
                        if (ld_commit) begin
                           entry_total_ff <= entry_total_ff + TOTAL_W'(1);
                        end
                     end
                     CMD_SWAP: begin
                        if (sw_bad) begin
                           st_ff    <= ST_BAD;
                           state_ff <= S_DONE;
                        end else begin
                           st_ff    <= ST_OK;
                           state_ff <= S_SW_CHK;
                        end
                     end
                     CMD_EVAL: begin
                        st_ff    <= ST_OK;
                        t_ff     <= '0;
                        state_ff <= S_EV_CLR;
                     end
                     default: begin
                        st_ff    <= ST_OK;
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_SW_CHK: begin
               cur_rank_ff <= rd_rank;
               cur_cnt_ff  <= rd_cnt;
               new_rank_ff <= sw_rank;
               i_ff        <= '0;
               if (rd_cnt == '0) begin
                  st_ff    <= ST_ZERO;
                  state_ff <= S_DONE;
               end else if ((sw_rank & mask) == (rd_rank & mask)) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SR_ADDR;
               end
            end
            S_SR_ADDR: begin
               state_ff <= S_SR_CMP;
            end
            S_SR_CMP: begin
               found_ff     <= i_ff[IDX_W-1:0];
               found_cnt_ff <= rd_cnt;
               if ((rd_rank & mask) == (new_rank_ff & mask)) begin
                  hit_ff   <= 1'b1;
                  state_ff <= S_SW_UPD;
               end else if (i_ff + TOTAL_W'(1) == entry_total_ff) begin
                  hit_ff   <= 1'b0;
                  state_ff <= S_SW_UPD;
               end else begin
                  i_ff     <= i_ff + TOTAL_W'(1);
                  state_ff <= S_SR_ADDR;
               end
            end
            S_SW_UPD: begin
               if (hit_ff) begin
                  state_ff <= empties ? S_SW_MOVE_RD : S_SW_DEC;
               end else if (empties) begin
                  state_ff <= S_DONE;
               end else if (entry_total_ff >= ENTRIES_FULL) begin
                  st_ff    <= ST_FULL;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SW_APPEND;
               end
            end
            S_SW_DEC: begin
               state_ff <= S_DONE;
            end
            S_SW_APPEND: begin
               entry_total_ff <= entry_total_ff + TOTAL_W'(1);
               state_ff       <= S_DONE;
            end
            S_SW_MOVE_RD: begin
               entry_total_ff <= entry_total_ff - TOTAL_W'(1);
               state_ff       <= S_SW_MOVE_WR;
            end
            S_SW_MOVE_WR: begin
               state_ff <= S_DONE;
            end
            S_EV_CLR: begin
               t_ff <= t_ff + TADDR_W'(1);
               i_ff <= '0;
               x_ff <= '0;
               j_ff <= '0;
               if (t_ff == TADDR_W'(TALLY_DEPTH - 1)) begin
                  state_ff <= (entry_total_ff == '0) ? S_EV_WRD : S_EV_ERD;
               end
            end
            S_EV_ERD: begin
               state_ff <= S_EV_ELAT;
            end
            S_EV_ELAT: begin
               cur_rank_ff <= rd_rank;
               cur_cnt_ff  <= rd_cnt;
               j_ff        <= 4'd0;
               k_ff        <= 4'd1;
               state_ff    <= S_EV_TRD;
            end
            S_EV_TRD: begin
               taddr_ff <= taddr;
               state_ff <= S_EV_TWR;
            end
            S_EV_TWR: begin
               // advance to next pair, then next entry
               if ({1'b0, k_ff} + POS_W'(1) < cc) begin
                  k_ff     <= k_ff + 4'd1;
                  state_ff <= S_EV_TRD;
               end else if ({1'b0, j_ff} + POS_W'(2) < cc) begin
                  j_ff     <= j_ff + 4'd1;
                  k_ff     <= j_ff + 4'd2;
                  state_ff <= S_EV_TRD;
               end else if (i_ff + TOTAL_W'(1) == entry_total_ff) begin
                  x_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= S_EV_WRD;
               end else begin
                  i_ff     <= i_ff + TOTAL_W'(1);
                  state_ff <= S_EV_ERD;
               end
            end
            S_EV_WRD: begin
               state_ff <= S_EV_WCMP;
            end
            S_EV_WCMP: begin
               if (!(j_ff == x_ff || tally_rd_ff > TALLY_W'(voter_total_ff >> 1))) begin
                  // candidate loses a pair: try the next one
                  if ({1'b0, x_ff} + POS_W'(1) == cc) begin
                     state_ff <= S_DONE;
                  end else begin
                     x_ff     <= x_ff + 4'd1;
                     j_ff     <= '0;
                     state_ff <= S_EV_WRD;
                  end
               end else if ({1'b0, j_ff} + POS_W'(1) == cc) begin
                  hw_ff    <= 1'b1;
                  win_ff   <= x_ff;
                  state_ff <= S_DONE;
               end else begin
                  j_ff     <= j_ff + 4'd1;
                  state_ff <= S_EV_WRD;
               end
            end
            S_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.status       <= st_ff;
                  rsp_ff.has_winner   <= hw_ff;
                  rsp_ff.winner       <= win_ff;
                  rsp_ff.entries_used <= entry_total_ff;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      entry_total_ff <= ENTRIES_FULL)
      else $error("entry total beyond table size");

   a_load_range: assert property (@(posedge clock) disable iff (reset)
      load_pos_ff <= CAND_MAX)
      else $error("load position beyond candidate limit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("ready right after an accepted beat");

   a_winner_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.has_winner || rsp_ff.winner == '0))
      else $error("winner set without has_winner");

endmodule
